/* rtl/svv_pkg.sv */
// Shared types and character codes for the semantic version string validator.
package svv_pkg;

  localparam int unsigned MAX_TEXT_DEF      = 128;
  localparam int unsigned MAX_QUALIFIER_DEF = 64;

  localparam int unsigned NUM_W = 32;
  localparam int unsigned LEN_W = 7;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic             valid_res;
    logic [NUM_W-1:0] major_num;
    logic [NUM_W-1:0] minor_num;
    logic [NUM_W-1:0] patch_num;
    logic [LEN_W-1:0] pre_length;
    logic [LEN_W-1:0] meta_length;
  } out_item_t;

endpackage

/* rtl/semver_string_validator_core.sv */
// Top level of the semantic version string validator.
// The block takes one character of a version text per transfer on the in_ channel and,
// on the transfer that carries last, gives one result on the out_ channel: the validity
// flag, the major, minor and patch numbers and the prerelease and build metadata lengths
// (all zero when the text is invalid). It takes one character per clock cycle while no
// waiting result stalls the input: each character is held in an input register and
// classified and folded into the parse state, with the decimal accumulate (multiply by
// ten and add) as the longest path. The result is registered behind the input register;
// a waiting result stalls the input only when the next final character arrives.
module semver_string_validator_core #(
  parameter int unsigned MAX_TEXT      = svv_pkg::MAX_TEXT_DEF,
  parameter int unsigned MAX_QUALIFIER = svv_pkg::MAX_QUALIFIER_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  svv_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output svv_pkg::out_item_t out_data
);

  localparam int unsigned TW    = $clog2(MAX_TEXT + 1);
  localparam int unsigned LEN_W = svv_pkg::LEN_W;
  localparam int unsigned NUM_W = svv_pkg::NUM_W;

  typedef enum logic [2:0] {
    PH_MAJOR,
    PH_MINOR,
    PH_PATCH,
    PH_PRE,
    PH_META
  } phase_t;

  logic               stg_v_r;
  svv_pkg::in_item_t  stg_r;
  phase_t             phase_r, phase_nxt;
  logic [NUM_W-1:0]   accum_r, accum_nxt;
  logic               dseen_r, dseen_nxt;
  logic [NUM_W-1:0]   major_r, major_nxt;
  logic [NUM_W-1:0]   minor_r, minor_nxt;
  logic [1:0]         ilen_r, ilen_nxt;
  logic               iall_r, iall_nxt;
  logic               ilead_r, ilead_nxt;
  logic [LEN_W-1:0]   pre_r, pre_nxt;
  logic [LEN_W-1:0]   meta_r, meta_nxt;
  logic [TW-1:0]      total_r, total_nxt;
  logic               err_r, err_nxt;
  logic               out_v_r;
  svv_pkg::out_item_t out_r, out_nxt;

  logic               stage_go;
  logic               is_dig, is_ident;
  logic [NUM_W+3:0]   prod;
  logic               in_pre;
  logic               ok;

  assign stage_go  = stg_v_r && (!stg_r.last || !out_v_r || out_ready);
  assign in_ready  = !stg_v_r || stage_go;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  assign is_dig   = (stg_r.ch >= svv_pkg::CH_ZERO) && (stg_r.ch <= svv_pkg::CH_NINE);
  assign is_ident = is_dig || (stg_r.ch == svv_pkg::CH_DASH)
                  || ((stg_r.ch >= svv_pkg::CH_LC_A) && (stg_r.ch <= svv_pkg::CH_LC_Z))
                  || ((stg_r.ch >= svv_pkg::CH_UC_A) && (stg_r.ch <= svv_pkg::CH_UC_Z));
  assign prod = ({4'd0, accum_r} << 3) + ({4'd0, accum_r} << 1) + (NUM_W + 4)'(stg_r.ch[3:0]);
  assign in_pre = (phase_r == PH_PRE);

  always_comb begin
    phase_nxt = phase_r;
    accum_nxt = accum_r;
    dseen_nxt = dseen_r;
    major_nxt = major_r;
    minor_nxt = minor_r;
    ilen_nxt  = ilen_r;
    iall_nxt  = iall_r;
    ilead_nxt = ilead_r;
    pre_nxt   = pre_r;
    meta_nxt  = meta_r;
    total_nxt = total_r;
    err_nxt   = err_r;
    ok        = 1'b0;
    out_nxt   = '0;

    if (total_r >= TW'(MAX_TEXT)) begin
      err_nxt = 1'b1;
    end else begin
      total_nxt = total_r + TW'(1);
    end

    if (phase_r == PH_MAJOR || phase_r == PH_MINOR || phase_r == PH_PATCH) begin
      if (is_dig) begin
        if (dseen_r && accum_r == '0) begin
          err_nxt = 1'b1;
        end
        if (prod[NUM_W+3:NUM_W] != 4'd0) begin
          err_nxt = 1'b1;
        end else begin
          accum_nxt = prod[NUM_W-1:0];
        end
        dseen_nxt = 1'b1;
      end else if (stg_r.ch == svv_pkg::CH_DOT) begin
        if (phase_r == PH_PATCH || !dseen_r) begin
          err_nxt = 1'b1;
        end else begin
          if (phase_r == PH_MAJOR) begin
            major_nxt = accum_r;
            phase_nxt = PH_MINOR;
          end else begin
            minor_nxt = accum_r;
            phase_nxt = PH_PATCH;
          end
          accum_nxt = '0;
          dseen_nxt = 1'b0;
        end
      end else if (stg_r.ch == svv_pkg::CH_DASH || stg_r.ch == svv_pkg::CH_PLUS) begin
        if (phase_r != PH_PATCH || !dseen_r) begin
          err_nxt = 1'b1;
        end
        phase_nxt = (stg_r.ch == svv_pkg::CH_DASH) ? PH_PRE : PH_META;
        ilen_nxt  = 2'd0;
        iall_nxt  = 1'b1;
        ilead_nxt = 1'b0;
      end else begin
        err_nxt = 1'b1;
      end
    end else if (stg_r.ch == svv_pkg::CH_PLUS) begin
      if (in_pre) begin
        if (ilen_r == 2'd0 || (iall_r && ilead_r && ilen_r == 2'd2)) begin
          err_nxt = 1'b1;
        end
        ilen_nxt  = 2'd0;
        iall_nxt  = 1'b1;
        ilead_nxt = 1'b0;
        phase_nxt = PH_META;
      end else begin
        err_nxt = 1'b1;
      end
    end else begin
      if (in_pre) begin
        if (pre_r >= LEN_W'(MAX_QUALIFIER)) begin
          err_nxt = 1'b1;
        end else begin
          pre_nxt = pre_r + LEN_W'(1);
        end
      end else begin
        if (meta_r >= LEN_W'(MAX_QUALIFIER)) begin
          err_nxt = 1'b1;
        end else begin
          meta_nxt = meta_r + LEN_W'(1);
        end
      end
      if (stg_r.ch == svv_pkg::CH_DOT) begin
        if (ilen_r == 2'd0 || (in_pre && iall_r && ilead_r && ilen_r == 2'd2)) begin
          err_nxt = 1'b1;
        end
        ilen_nxt  = 2'd0;
        iall_nxt  = 1'b1;
        ilead_nxt = 1'b0;
      end else if (is_ident) begin
        if (ilen_r == 2'd0 && stg_r.ch == svv_pkg::CH_ZERO) begin
          ilead_nxt = 1'b1;
        end
        if (!is_dig) begin
          iall_nxt = 1'b0;
        end
        if (ilen_r != 2'd2) begin
          ilen_nxt = ilen_r + 2'd1;
        end
      end else begin
        err_nxt = 1'b1;
      end
    end

    if (stg_r.last) begin
      case (phase_nxt)
        PH_MAJOR, PH_MINOR: err_nxt = 1'b1;
        PH_PATCH: begin
          if (!dseen_nxt) begin
            err_nxt = 1'b1;
          end
        end
        PH_PRE: begin
          if (ilen_nxt == 2'd0 || (iall_nxt && ilead_nxt && ilen_nxt == 2'd2)) begin
            err_nxt = 1'b1;
          end
        end
        PH_META: begin
          if (ilen_nxt == 2'd0) begin
            err_nxt = 1'b1;
          end
        end
        default: err_nxt = 1'b1;
      endcase
      ok = !err_nxt;
      out_nxt.valid_res   = ok;
      out_nxt.major_num   = ok ? major_nxt : '0;
      out_nxt.minor_num   = ok ? minor_nxt : '0;
      out_nxt.patch_num   = ok ? accum_nxt : '0;
      out_nxt.pre_length  = ok ? pre_nxt : '0;
      out_nxt.meta_length = ok ? meta_nxt : '0;
      phase_nxt = PH_MAJOR;
      accum_nxt = '0;
      dseen_nxt = 1'b0;
      major_nxt = '0;
      minor_nxt = '0;
      ilen_nxt  = 2'd0;
      iall_nxt  = 1'b1;
      ilead_nxt = 1'b0;
      pre_nxt   = '0;
      meta_nxt  = '0;
      total_nxt = '0;
      err_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      stg_r <= in_data;
    end
    if (stage_go && stg_r.last) begin
      out_r <= out_nxt;
    end
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      out_v_r <= 1'b0;
      phase_r <= PH_MAJOR;
      accum_r <= '0;
      dseen_r <= 1'b0;
      major_r <= '0;
      minor_r <= '0;
      ilen_r  <= 2'd0;
      iall_r  <= 1'b1;
      ilead_r <= 1'b0;
      pre_r   <= '0;
      meta_r  <= '0;
      total_r <= '0;
      err_r   <= 1'b0;
    end else begin
      if (in_ready) begin
        stg_v_r <= in_valid;
      end
      if (stage_go && stg_r.last) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      if (stage_go) begin
        phase_r <= phase_nxt;
        accum_r <= accum_nxt;
        dseen_r <= dseen_nxt;
        major_r <= major_nxt;
        minor_r <= minor_nxt;
        ilen_r  <= ilen_nxt;
        iall_r  <= iall_nxt;
        ilead_r <= ilead_nxt;
        pre_r   <= pre_nxt;
        meta_r  <= meta_nxt;
        total_r <= total_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule

/* rtl/svv_checker.sv */
// Port-level checker for the semantic version string validator, bound to the top level.
module svv_checker #(
  parameter int unsigned MAX_QUALIFIER = svv_pkg::MAX_QUALIFIER_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input svv_pkg::out_item_t out_data
);

  localparam int unsigned LEN_W = svv_pkg::LEN_W;

  // A result that is not taken stays offered unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // An invalid text reports zero for every number and length.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.valid_res |-> out_data.major_num == '0
      && out_data.minor_num == '0 && out_data.patch_num == '0
      && out_data.pre_length == '0 && out_data.meta_length == '0)
    else $error("invalid result carries nonzero fields");

  // Qualifier lengths of a valid text never pass the qualifier limit.
  a_len_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.valid_res |-> out_data.pre_length <= LEN_W'(MAX_QUALIFIER)
      && out_data.meta_length <= LEN_W'(MAX_QUALIFIER))
    else $error("qualifier length above limit");

  // Reset leaves no result pending and the input open.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind semver_string_validator_core svv_checker #(.MAX_QUALIFIER(MAX_QUALIFIER)) u_svv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
